// ===== design/cpp_pkg.sv =====
package cpp_pkg;

    localparam int SCREEN_SIZE_DEF = 128;

    localparam int POS_W   = 24;
    localparam int ANGLE_W = 16;
    localparam int FOV_W   = 8;
    localparam int TRIG_W  = 16;
    localparam int COORD_W = 29;
    localparam int PIX_W   = 16;
    localparam int QUOT_W  = 16;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_PITCH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_YAW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_ROLL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FOV       = 3'd6;

    localparam logic signed [POS_W-1:0] CAM_Z_RESET = -24'sd25600;
    localparam logic [FOV_W-1:0]        FOV_RESET   = 8'd60;
    localparam logic [FOV_W-1:0]        FOV_MIN     = 8'd1;
    localparam logic [FOV_W-1:0]        FOV_MAX     = 8'd180;

    localparam logic [15:0] SIN_A = 16'd25736;
    localparam logic [15:0] SIN_B = 16'd10512;
    localparam logic [15:0] SIN_C = 16'd1160;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    // ceil(2^32 / 360); exact for every numerator below 2^23.
    localparam logic [23:0] RECIP_360 = 24'd11930465;
    localparam logic [22:0] HALF_DEG  = 23'd180;

    localparam logic [1:0] SLOT_YAW   = 2'd0;
    localparam logic [1:0] SLOT_PITCH = 2'd1;
    localparam logic [1:0] SLOT_ROLL  = 2'd2;
    localparam logic [1:0] SLOT_FOV   = 2'd3;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_cam;

    typedef struct packed {
        logic signed [TRIG_W-1:0] yaw_s;
        logic signed [TRIG_W-1:0] yaw_c;
        logic signed [TRIG_W-1:0] pitch_s;
        logic signed [TRIG_W-1:0] pitch_c;
        logic signed [TRIG_W-1:0] roll_s;
        logic signed [TRIG_W-1:0] roll_c;
    } t_trig;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
        logic front;
    } t_tag;

endpackage

// ===== design/camera_point_projection.sv =====
// Channel   Direction  Ready          Payload
// s         in         o_s_tready     i_s_tdata: point_x, point_y, point_z
// m         out        i_m_tready     o_m_tdata: screen_x, screen_y; o_m_tuser: visible
// cfg       in         o_cfg_ready    i_cfg_index, i_cfg_data
//
// One point is taken per cycle while the sequencer is idle and the output is not stalled.
// After reset and after every configuration write the sine, cosine and focal-length
// sequencer runs its half-angle, trig, focal set-up and division steps, during which no point is taken.
// A stalled output holds the whole pipeline; reset is synchronous and active low.
module camera_point_projection #(
    parameter int SCREEN_SIZE = cpp_pkg::SCREEN_SIZE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [71:0]                     i_s_tdata,   // point_x, point_y, point_z
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [31:0]                     o_m_tdata,   // screen_x, screen_y
    output logic                            o_m_tuser,   // visible
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cpp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cpp_pkg::POS_W-1:0]       i_cfg_data
);
    localparam int HALF    = SCREEN_SIZE / 2;
    localparam int FOCAL_W = $clog2(HALF) + 16;
    localparam int CW      = cpp_pkg::COORD_W;
    localparam int NW      = CW + FOCAL_W + 1;
    localparam int DW      = CW + 8;
    localparam int LW      = NW + DW + cpp_pkg::QUOT_W;
    localparam int QB      = cpp_pkg::QUOT_W;

    cpp_pkg::t_cam          w_cam;
    cpp_pkg::t_trig         w_trig;
    logic [FOCAL_W-1:0]     w_focal;
    logic                   w_busy, w_en;

    logic                   r_v0;
    logic signed [CW-1:0]   r_x0, r_y0, r_z0;

    logic                   w_v1, w_v2, w_v3;
    logic signed [CW-1:0]   w_x1, w_z1, w_y1, w_y2, w_z2, w_x2, w_x3, w_y3, w_z3;
    logic signed [cpp_pkg::TRIG_W-1:0] w_yaw_ns;

    logic                   r_v7;
    logic signed [NW-1:0]   r_px, r_py;
    logic signed [CW-1:0]   r_z7;

    logic                   r_v8;
    logic [NW-1:0]          r_mx, r_my;
    logic [DW-1:0]          r_den8;
    cpp_pkg::t_tag          r_tag8;
    logic [CW-1:0]          w_zd;
    logic [NW-1:0]          w_mx, w_my;
    logic [DW-1:0]          w_den;

    logic                   c_v   [QB+1];
    logic [NW-1:0]          c_rx  [QB+1];
    logic [NW-1:0]          c_ry  [QB+1];
    logic [DW-1:0]          c_den [QB+1];
    logic [QB-1:0]          c_qx  [QB+1];
    logic [QB-1:0]          c_qy  [QB+1];
    cpp_pkg::t_tag          c_tag [QB+1];

    logic                   r_ov;
    logic [15:0]            r_sx, r_sy;
    logic                   r_vis;
    logic signed [18:0]     w_sumx, w_sumy;
    logic [15:0]            w_sx, w_sy;
    cpp_pkg::t_tag          w_tag;

    cpp_cfg #(.SCREEN_SIZE(SCREEN_SIZE), .FOCAL_W(FOCAL_W)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cam       (w_cam),
        .o_trig      (w_trig),
        .o_focal     (w_focal),
        .o_busy      (w_busy)
    );

    assign o_cfg_ready = 1'b1;
    assign w_en        = !r_ov || i_m_tready;
    assign o_s_tready  = w_en && !w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_s_tvalid && !w_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x0 <= CW'($signed(i_s_tdata[23:0])) - CW'(w_cam.x);
            r_y0 <= CW'($signed(i_s_tdata[47:24])) - CW'(w_cam.y);
            r_z0 <= CW'($signed(i_s_tdata[71:48])) - CW'(w_cam.z);
        end
    end

    // Yaw rotates the opposite way around, so its sine enters negated.
    assign w_yaw_ns = -w_trig.yaw_s;

    cpp_rot u_yaw (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (r_v0),
        .i_p (r_x0), .i_q (r_z0), .i_t (r_y0),
        .i_c (w_trig.yaw_c), .i_s (w_yaw_ns),
        .o_valid (w_v1), .o_a (w_x1), .o_b (w_z1), .o_t (w_y1)
    );

    cpp_rot u_pitch (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (w_v1),
        .i_p (w_y1), .i_q (w_z1), .i_t (w_x1),
        .i_c (w_trig.pitch_c), .i_s (w_trig.pitch_s),
        .o_valid (w_v2), .o_a (w_y2), .o_b (w_z2), .o_t (w_x2)
    );

    cpp_rot u_roll (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (w_v2),
        .i_p (w_x2), .i_q (w_y2), .i_t (w_z2),
        .i_c (w_trig.roll_c), .i_s (w_trig.roll_s),
        .o_valid (w_v3), .o_a (w_x3), .o_b (w_y3), .o_t (w_z3)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (w_en) begin
            r_v7 <= w_v3;
            r_v8 <= r_v7;
        end
    end

    assign w_zd  = (r_z7 <= CW'(256)) ? CW'(256) : CW'(r_z7);
    assign w_den = {w_zd[DW-9:0], 8'b0};
    assign w_mx  = r_px[NW-1] ? NW'(-r_px) : NW'(r_px);
    assign w_my  = r_py[NW-1] ? NW'(-r_py) : NW'(r_py);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px <= NW'(w_x3) * NW'({1'b0, w_focal});
            r_py <= NW'(w_y3) * NW'({1'b0, w_focal});
            r_z7 <= w_z3;
            r_mx <= w_mx;
            r_my <= w_my;
            r_den8 <= w_den;
            r_tag8.neg_x <= r_px[NW-1];
            r_tag8.neg_y <= r_py[NW-1];
            r_tag8.ovf_x <= (LW'(w_mx) >= (LW'(w_den) << QB));
            r_tag8.ovf_y <= (LW'(w_my) >= (LW'(w_den) << QB));
            r_tag8.front <= (r_z7 > CW'(256));
        end
    end

    assign c_v[0]   = r_v8;
    assign c_rx[0]  = r_mx;
    assign c_ry[0]  = r_my;
    assign c_den[0] = r_den8;
    assign c_qx[0]  = '0;
    assign c_qy[0]  = '0;
    assign c_tag[0] = r_tag8;

    for (genvar i = 0; i < QB; i++) begin : g_cell
        cpp_div_cell #(.NW(NW), .DW(DW), .K(QB - 1 - i)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (c_v[i]),
            .i_rem_x (c_rx[i]),
            .i_rem_y (c_ry[i]),
            .i_den   (c_den[i]),
            .i_qx    (c_qx[i]),
            .i_qy    (c_qy[i]),
            .i_tag   (c_tag[i]),
            .o_valid (c_v[i+1]),
            .o_rem_x (c_rx[i+1]),
            .o_rem_y (c_ry[i+1]),
            .o_den   (c_den[i+1]),
            .o_qx    (c_qx[i+1]),
            .o_qy    (c_qy[i+1]),
            .o_tag   (c_tag[i+1])
        );
    end

    always_comb begin
        logic signed [18:0] qx, qy;
        w_tag = c_tag[QB];
        qx = w_tag.ovf_x ? 19'sd65536 : 19'($signed({1'b0, c_qx[QB]}));
        qy = w_tag.ovf_y ? 19'sd65536 : 19'($signed({1'b0, c_qy[QB]}));
        if (w_tag.neg_x) begin
            qx = -qx;
        end
        if (w_tag.neg_y) begin
            qy = -qy;
        end
        w_sumx = qx + 19'(HALF);
        w_sumy = qy + 19'(HALF);
        if (w_sumx > 19'sd32767) begin
            w_sx = 16'h7FFF;
        end else if (w_sumx < -19'sd32768) begin
            w_sx = 16'h8000;
        end else begin
            w_sx = w_sumx[15:0];
        end
        if (w_sumy > 19'sd32767) begin
            w_sy = 16'h7FFF;
        end else if (w_sumy < -19'sd32768) begin
            w_sy = 16'h8000;
        end else begin
            w_sy = w_sumy[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= c_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sx  <= w_sx;
            r_sy  <= w_sy;
            r_vis <= w_tag.front && !w_sx[15] && ($signed(w_sx) < $signed(16'(SCREEN_SIZE)))
                     && !w_sy[15] && ($signed(w_sy) < $signed(16'(SCREEN_SIZE)));
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_sy, r_sx};
    assign o_m_tuser  = r_vis;

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_s_tready)
        else $error("point taken while camera constants are being computed");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_m_tready) |-> !o_s_tready)
        else $error("point taken while the output is stalled");

    a_vis_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_vis) |-> (!r_sx[15] && !r_sy[15]
            && ($signed(r_sx) < $signed(16'(SCREEN_SIZE)))
            && ($signed(r_sy) < $signed(16'(SCREEN_SIZE)))))
        else $error("visible item lies off screen");

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> w_busy)
        else $error("configuration write did not restart the constant sequencer");

endmodule

// ===== design/cpp_cfg.sv =====
module cpp_cfg #(
    parameter int SCREEN_SIZE = cpp_pkg::SCREEN_SIZE_DEF,
    parameter int FOCAL_W     = $clog2(SCREEN_SIZE / 2) + 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [cpp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cpp_pkg::POS_W-1:0]        i_cfg_data,
    output cpp_pkg::t_cam                    o_cam,
    output cpp_pkg::t_trig                   o_trig,
    output logic [FOCAL_W-1:0]               o_focal,
    output logic                             o_busy
);
    localparam int HALF    = SCREEN_SIZE / 2;
    localparam int FNUM_W  = $clog2(HALF) + 23;
    localparam int CNT_W   = $clog2(FNUM_W + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_HB   = 5'b00010,
        ST_TRIG = 5'b00100,
        ST_FSET = 5'b01000,
        ST_DIV  = 5'b10000
    } t_state;

    t_state                 r_state;
    cpp_pkg::t_cam          r_cam;
    logic [15:0]            r_pitch, r_yaw, r_roll, r_hb;
    logic [7:0]             r_fov;
    logic [2:0]             r_e;
    logic [1:0]             r_ph;
    logic [15:0]            r_z2, r_r;
    logic signed [15:0]     r_trig [8];
    logic [15:0]            r_rem, r_den;
    logic [FNUM_W-1:0]      r_num;
    logic [CNT_W-1:0]       r_cnt;
    logic [FOCAL_W-1:0]     r_focal;

    logic [7:0]             w_fcl;
    logic [22:0]            w_n;
    logic [46:0]            w_hbp;
    logic [15:0]            w_base, w_ang, w_ma, w_mb, w_ms;
    logic [14:0]            w_off;
    logic [31:0]            w_mp;
    logic signed [15:0]     w_v, w_s, w_c;
    logic [15:0]            w_scl, w_ccl, w_t;
    logic                   w_ge;

    always_comb begin
        if (r_fov < cpp_pkg::FOV_MIN) begin
            w_fcl = cpp_pkg::FOV_MIN;
        end else if (r_fov > cpp_pkg::FOV_MAX) begin
            w_fcl = cpp_pkg::FOV_MAX;
        end else begin
            w_fcl = r_fov;
        end
        w_n   = {w_fcl, 15'b0} + cpp_pkg::HALF_DEG;
        w_hbp = 47'(w_n) * 47'(cpp_pkg::RECIP_360);

        case (r_e[2:1])
            cpp_pkg::SLOT_YAW:   w_base = 16'd0 - r_yaw;
            cpp_pkg::SLOT_PITCH: w_base = 16'd0 - r_pitch;
            cpp_pkg::SLOT_ROLL:  w_base = 16'd0 - r_roll;
            default:             w_base = r_hb;
        endcase
        w_ang = w_base + (r_e[0] ? cpp_pkg::QUARTER_TURN : 16'd0);
        w_off = w_ang[14] ? 15'(cpp_pkg::QUARTER_TURN - {2'b0, w_ang[13:0]})
                          : {1'b0, w_ang[13:0]};

        case (r_ph)
            2'd0: begin
                w_ma = {1'b0, w_off};
                w_mb = {1'b0, w_off};
            end
            2'd1: begin
                w_ma = cpp_pkg::SIN_C;
                w_mb = r_z2;
            end
            2'd2: begin
                w_ma = cpp_pkg::SIN_B - r_r;
                w_mb = r_z2;
            end
            default: begin
                w_ma = cpp_pkg::SIN_A - r_r;
                w_mb = {1'b0, w_off};
            end
        endcase
        w_mp = 32'(w_ma) * 32'(w_mb);
        w_ms = w_mp[29:14];
        w_v  = w_ang[15] ? -$signed(w_ms) : $signed(w_ms);

        w_s   = r_trig[6];
        w_c   = r_trig[7];
        w_scl = (w_s <= 16'sd0) ? 16'd1 : 16'(w_s);
        w_ccl = (w_c < 16'sd0) ? 16'd0 : 16'(w_c);

        w_t  = {r_rem[14:0], r_num[FNUM_W-1]};
        w_ge = (w_t >= r_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HB;
            r_cam.x <= '0;
            r_cam.y <= '0;
            r_cam.z <= cpp_pkg::CAM_Z_RESET;
            r_pitch <= '0;
            r_yaw   <= '0;
            r_roll  <= '0;
            r_fov   <= cpp_pkg::FOV_RESET;
            r_e     <= '0;
            r_ph    <= '0;
            r_cnt   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cpp_pkg::CFG_CAM_X:     r_cam.x <= i_cfg_data;
                cpp_pkg::CFG_CAM_Y:     r_cam.y <= i_cfg_data;
                cpp_pkg::CFG_CAM_Z:     r_cam.z <= i_cfg_data;
                cpp_pkg::CFG_CAM_PITCH: r_pitch <= i_cfg_data[15:0];
                cpp_pkg::CFG_CAM_YAW:   r_yaw   <= i_cfg_data[15:0];
                cpp_pkg::CFG_CAM_ROLL:  r_roll  <= i_cfg_data[15:0];
                cpp_pkg::CFG_FOV:       r_fov   <= i_cfg_data[7:0];
                default: ;
            endcase
            r_state <= ST_HB;
            r_e     <= '0;
            r_ph    <= '0;
        end else begin
            case (r_state)
                ST_HB: begin
                    r_hb    <= {1'b0, w_hbp[46:32]};
                    r_state <= ST_TRIG;
                end
                ST_TRIG: begin
                    r_ph <= r_ph + 2'd1;
                    case (r_ph)
                        2'd0:    r_z2 <= w_ms;
                        2'd1:    r_r  <= w_ms;
                        2'd2:    r_r  <= w_ms;
                        default: begin
                            r_trig[r_e] <= w_v;
                            r_e <= r_e + 3'd1;
                            if (r_e == 3'd7) begin
                                r_state <= ST_FSET;
                            end
                        end
                    endcase
                end
                ST_FSET: begin
                    r_num   <= FNUM_W'(w_ccl) * FNUM_W'(HALF * 256) + FNUM_W'(w_scl >> 1);
                    r_den   <= w_scl;
                    r_rem   <= '0;
                    r_cnt   <= CNT_W'(FNUM_W);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= w_ge ? (w_t - r_den) : w_t;
                    r_num <= {r_num[FNUM_W-2:0], w_ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_focal <= {r_num[FOCAL_W-2:0], w_ge};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_cam          = r_cam;
    assign o_trig.yaw_s   = r_trig[0];
    assign o_trig.yaw_c   = r_trig[1];
    assign o_trig.pitch_s = r_trig[2];
    assign o_trig.pitch_c = r_trig[3];
    assign o_trig.roll_s  = r_trig[4];
    assign o_trig.roll_c  = r_trig[5];
    assign o_focal        = r_focal;
    assign o_busy         = (r_state != ST_IDLE);

endmodule

// ===== design/cpp_rot.sv =====
module cpp_rot (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_en,
    input  logic                                     i_valid,
    input  logic signed [cpp_pkg::COORD_W-1:0]       i_p,
    input  logic signed [cpp_pkg::COORD_W-1:0]       i_q,
    input  logic signed [cpp_pkg::COORD_W-1:0]       i_t,
    input  logic signed [cpp_pkg::TRIG_W-1:0]        i_c,
    input  logic signed [cpp_pkg::TRIG_W-1:0]        i_s,
    output logic                                     o_valid,
    output logic signed [cpp_pkg::COORD_W-1:0]       o_a,
    output logic signed [cpp_pkg::COORD_W-1:0]       o_b,
    output logic signed [cpp_pkg::COORD_W-1:0]       o_t
);
    localparam int CW = cpp_pkg::COORD_W;
    localparam int PW = CW + cpp_pkg::TRIG_W;

    logic                   r_v1, r_v2;
    logic signed [PW-1:0]   r_pc, r_qs, r_qc, r_ps;
    logic signed [CW-1:0]   r_t1, r_a, r_b, r_t2;
    logic signed [PW:0]     w_a, w_b;

    // a = p*c - q*s and b = q*c + p*s, floored back to the coordinate scale.
    assign w_a = (PW+1)'(r_pc) - (PW+1)'(r_qs);
    assign w_b = (PW+1)'(r_qc) + (PW+1)'(r_ps);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc <= PW'(i_p) * PW'(i_c);
            r_qs <= PW'(i_q) * PW'(i_s);
            r_qc <= PW'(i_q) * PW'(i_c);
            r_ps <= PW'(i_p) * PW'(i_s);
            r_t1 <= i_t;
            r_a  <= w_a[CW+13:14];
            r_b  <= w_b[CW+13:14];
            r_t2 <= r_t1;
        end
    end

    assign o_valid = r_v2;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_t     = r_t2;

endmodule

// ===== design/cpp_div_cell.sv =====
module cpp_div_cell #(
    parameter int NW = 48,
    parameter int DW = 37,
    parameter int K  = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [NW-1:0]               i_rem_x,
    input  logic [NW-1:0]               i_rem_y,
    input  logic [DW-1:0]               i_den,
    input  logic [cpp_pkg::QUOT_W-1:0]  i_qx,
    input  logic [cpp_pkg::QUOT_W-1:0]  i_qy,
    input  cpp_pkg::t_tag               i_tag,
    output logic                        o_valid,
    output logic [NW-1:0]               o_rem_x,
    output logic [NW-1:0]               o_rem_y,
    output logic [DW-1:0]               o_den,
    output logic [cpp_pkg::QUOT_W-1:0]  o_qx,
    output logic [cpp_pkg::QUOT_W-1:0]  o_qy,
    output cpp_pkg::t_tag               o_tag
);
    localparam int LW = NW + DW + cpp_pkg::QUOT_W;

    logic [LW-1:0]  w_sh;
    logic           w_gx, w_gy;
    logic           r_v;
    logic [NW-1:0]  r_rx, r_ry;
    logic [DW-1:0]  r_den;
    logic [cpp_pkg::QUOT_W-1:0] r_qx, r_qy;
    cpp_pkg::t_tag  r_tag;

    assign w_sh = LW'(i_den) << K;
    assign w_gx = (LW'(i_rem_x) >= w_sh);
    assign w_gy = (LW'(i_rem_y) >= w_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx  <= w_gx ? (i_rem_x - w_sh[NW-1:0]) : i_rem_x;
            r_ry  <= w_gy ? (i_rem_y - w_sh[NW-1:0]) : i_rem_y;
            r_qx  <= i_qx | (cpp_pkg::QUOT_W'(w_gx) << K);
            r_qy  <= i_qy | (cpp_pkg::QUOT_W'(w_gy) << K);
            r_den <= i_den;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_v;
    assign o_rem_x = r_rx;
    assign o_rem_y = r_ry;
    assign o_den   = r_den;
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;
    assign o_tag   = r_tag;

endmodule

// ===== tb/cpp_checker.sv =====
`timescale 1ns / 1ps

module cpp_checker #(
    parameter int SCREEN_SIZE = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [71:0]                   i_s_tdata,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [31:0]                   i_m_tdata,
    input  logic                          i_m_tuser,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [cpp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cpp_pkg::POS_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               vis;
    } t_pixel;

    longint cx, cy, cz;
    logic [15:0] pitch, yaw, roll;
    logic [7:0]  fov;
    t_pixel expected_pixels[$];

    assign o_pending = expected_pixels.size();

    function automatic longint quarter_wave(longint z);
        longint z2, r;
        z2 = (z * z) >>> 14;
        r = (1160 * z2) >>> 14;
        r = 10512 - r;
        r = (r * z2) >>> 14;
        r = 25736 - r;
        return (r * z) >>> 14;
    endfunction

    function automatic longint sine14(logic [15:0] a);
        longint off, v;
        off = a[13:0];
        if (a[14]) off = 16384 - off;
        v = quarter_wave(off);
        return a[15] ? -v : v;
    endfunction

    function automatic longint cosine14(logic [15:0] a);
        return sine14(a + 16'd16384);
    endfunction

    function automatic longint shr14(longint v);
        return v >>> 14;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic t_pixel project_point(logic [71:0] d);
        longint x, y, z, s, c, nx, ny, nz, zd, focal, sx, sy, half;
        longint f, hb;
        t_pixel p;
        half = SCREEN_SIZE / 2;
        x = longint'($signed(d[23:0])) - cx;
        y = longint'($signed(d[47:24])) - cy;
        z = longint'($signed(d[71:48])) - cz;
        s = sine14(-yaw); c = cosine14(-yaw);
        nx = shr14(x * c + z * s); nz = shr14(z * c - x * s);
        x = nx; z = nz;
        s = sine14(-pitch); c = cosine14(-pitch);
        ny = shr14(y * c - z * s); nz = shr14(y * s + z * c);
        y = ny; z = nz;
        s = sine14(-roll); c = cosine14(-roll);
        nx = shr14(x * c - y * s); ny = shr14(x * s + y * c);
        x = nx; y = ny;
        f = fov;
        if (f < 1) f = 1;
        if (f > 180) f = 180;
        hb = (f * 32768 + 180) / 360;
        s = sine14(hb[15:0]); c = cosine14(hb[15:0]);
        if (s <= 0) s = 1;
        if (c < 0) c = 0;
        focal = (half * 256 * c + s / 2) / s;
        zd = (z <= 256) ? 256 : z;
        sx = clip16((x * focal) / (zd * 256) + half);
        sy = clip16((y * focal) / (zd * 256) + half);
        p.sx = sx[15:0];
        p.sy = sy[15:0];
        p.vis = (z > 256) && sx >= 0 && sx < SCREEN_SIZE && sy >= 0 && sy < SCREEN_SIZE;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            cx = 0; cy = 0; cz = -25600;
            pitch = 0; yaw = 0; roll = 0; fov = 60;
            o_fail_count = 0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    cpp_pkg::CFG_CAM_X:     cx = $signed(i_cfg_data);
                    cpp_pkg::CFG_CAM_Y:     cy = $signed(i_cfg_data);
                    cpp_pkg::CFG_CAM_Z:     cz = $signed(i_cfg_data);
                    cpp_pkg::CFG_CAM_PITCH: pitch = i_cfg_data[15:0];
                    cpp_pkg::CFG_CAM_YAW:   yaw = i_cfg_data[15:0];
                    cpp_pkg::CFG_CAM_ROLL:  roll = i_cfg_data[15:0];
                    cpp_pkg::CFG_FOV:       fov = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) expected_pixels.push_back(project_point(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected item", 0, 0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_m_tdata[15:0] !== want.sx)
                        report_mismatch("screen_x", $signed(i_m_tdata[15:0]), want.sx);
                    if (i_m_tdata[31:16] !== want.sy)
                        report_mismatch("screen_y", $signed(i_m_tdata[31:16]), want.sy);
                    if (i_m_tuser !== want.vis)
                        report_mismatch("visible", i_m_tuser, want.vis);
                end
            end
        end
    end
endmodule

// ===== tb/tb_camera_point_projection.sv =====
`timescale 1ns / 1ps

module tb_camera_point_projection;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid, s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid, m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid, cfg_ready;
    logic [cpp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cpp_pkg::POS_W-1:0]     cfg_data;
    int  fail_count, pending, idle_cycles;
    bit  calm, hold_sink;

    camera_point_projection dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .o_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    cpp_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        m_tready = 0;
        @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                m_tready <= 0;
                repeat (300) @(posedge i_clk);
                hold_sink = 0;
            end
            m_tready <= calm || ($urandom_range(99) >= 26);
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [cpp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cpp_pkg::POS_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 0;
    endtask

    task automatic send_point(input logic [23:0] px, input logic [23:0] py, input logic [23:0] pz);
        while (!calm && $urandom_range(99) < 26) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {pz, py, px};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain;
        s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(20000)) - 10000);
            2: return {$urandom_range(1) ? 8'hff : 8'h00, 16'($urandom)};
            default: return 24'($signed($urandom_range(100000)) - 50000);
        endcase
    endfunction

    task automatic random_setting;
        write_reg(cpp_pkg::CFG_CAM_X, rand_coord());
        write_reg(cpp_pkg::CFG_CAM_Y, rand_coord());
        write_reg(cpp_pkg::CFG_CAM_Z, rand_coord());
        write_reg(cpp_pkg::CFG_CAM_PITCH, {8'h0, 16'($urandom)});
        write_reg(cpp_pkg::CFG_CAM_YAW, {8'h0, 16'($urandom)});
        write_reg(cpp_pkg::CFG_CAM_ROLL, {8'h0, 16'($urandom)});
        write_reg(cpp_pkg::CFG_FOV, {16'h0, 8'($urandom_range(255))});
    endtask

    initial begin
        i_rst_n = 0;
        s_tvalid = 0; s_tdata = 0;
        cfg_valid = 0; cfg_index = cpp_pkg::CFG_CAM_X; cfg_data = 0;
        calm = 0; hold_sink = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_point(24'h0, 24'h0, 24'h0);
        send_point(24'h7fffff, 24'h7fffff, 24'h7fffff);
        send_point(24'h800000, 24'h800000, 24'h800000);
        send_point(24'h7fffff, 24'h800000, 24'h0);
        send_point(24'd2560, 24'd2560, 24'd0);
        send_point(24'd256, 24'hffff00, -24'sd25344);
        send_point(24'd100, 24'd100, -24'sd25600);
        send_point(24'd5000, -24'sd5000, -24'sd25599);
        send_point(24'h0, 24'h0, 24'h800000);
        drain();

        write_reg(cpp_pkg::CFG_FOV, {16'h0, cpp_pkg::FOV_MAX});
        send_point(24'd1000, 24'd500, 24'd0);
        drain();
        write_reg(cpp_pkg::CFG_FOV, 24'd0);
        send_point(24'd10, 24'd10, 24'd0);
        send_point(24'd256, 24'd0, 24'd0);
        drain();
        write_reg(cpp_pkg::CFG_FOV, 24'd255);
        send_point(24'd1000, 24'd500, 24'd0);
        drain();
        write_reg(cpp_pkg::CFG_CAM_X, 24'h7fffff);
        write_reg(cpp_pkg::CFG_CAM_Y, 24'h800000);
        write_reg(cpp_pkg::CFG_CAM_Z, 24'h7fffff);
        write_reg(cpp_pkg::CFG_CAM_PITCH, 24'h007fff);
        write_reg(cpp_pkg::CFG_CAM_YAW, 24'h008000);
        write_reg(cpp_pkg::CFG_CAM_ROLL, 24'h00ffff);
        write_reg(cpp_pkg::CFG_FOV, {16'h0, cpp_pkg::FOV_MIN});
        send_point(24'h800000, 24'h7fffff, 24'h800000);
        send_point(24'h0, 24'h0, 24'h0);
        drain();

        for (int phase = 0; phase < 15; phase++) begin
            if (phase == 0) begin
                write_reg(cpp_pkg::CFG_CAM_X, 24'h0);
                write_reg(cpp_pkg::CFG_CAM_Y, 24'h0);
                write_reg(cpp_pkg::CFG_CAM_Z, cpp_pkg::CAM_Z_RESET);
                write_reg(cpp_pkg::CFG_CAM_PITCH, 24'h0);
                write_reg(cpp_pkg::CFG_CAM_YAW, 24'h0);
                write_reg(cpp_pkg::CFG_CAM_ROLL, 24'h0);
                write_reg(cpp_pkg::CFG_FOV, {16'h0, cpp_pkg::FOV_RESET});
            end else begin
                random_setting();
            end
            calm = (phase == 3);
            if (phase == 5) hold_sink = 1;
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(3) == 0)
                    send_point(24'($urandom), 24'($urandom), 24'($urandom));
                else
                    send_point(24'($signed($urandom_range(16000)) - 8000),
                               24'($signed($urandom_range(16000)) - 8000),
                               24'($signed($urandom_range(60000)) - 30000));
            end
            calm = 0;
            drain();
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== files.f =====
design/cpp_pkg.sv
design/cpp_cfg.sv
design/cpp_rot.sv
design/cpp_div_cell.sv
design/camera_point_projection.sv
tb/cpp_checker.sv
tb/tb_camera_point_projection.sv
